// ----- hdl/rsxu_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package rsxu_pkg;

	localparam int XLEN        = 32;
	localparam int REG_W       = 5;
	localparam int FUNC_W      = 5;
	localparam int MADDR_W     = 12;
	localparam int NUM_REGS    = 32;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [FUNC_W-1:0] FUNC_ADD  = 5'd0;
	localparam logic [FUNC_W-1:0] FUNC_SUB  = 5'd1;
	localparam logic [FUNC_W-1:0] FUNC_AND  = 5'd2;
	localparam logic [FUNC_W-1:0] FUNC_OR   = 5'd3;
	localparam logic [FUNC_W-1:0] FUNC_XOR  = 5'd4;
	localparam logic [FUNC_W-1:0] FUNC_NOR  = 5'd5;
	localparam logic [FUNC_W-1:0] FUNC_SLT  = 5'd6;
	localparam logic [FUNC_W-1:0] FUNC_SLL  = 5'd7;
	localparam logic [FUNC_W-1:0] FUNC_SRA  = 5'd8;
	localparam logic [FUNC_W-1:0] FUNC_ADDI = 5'd9;
	localparam logic [FUNC_W-1:0] FUNC_ANDI = 5'd10;
	localparam logic [FUNC_W-1:0] FUNC_ORI  = 5'd11;
	localparam logic [FUNC_W-1:0] FUNC_XORI = 5'd12;
	localparam logic [FUNC_W-1:0] FUNC_SLTI = 5'd13;
	localparam logic [FUNC_W-1:0] FUNC_LW   = 5'd14;
	localparam logic [FUNC_W-1:0] FUNC_LB   = 5'd15;
	localparam logic [FUNC_W-1:0] FUNC_SW   = 5'd16;
	localparam logic [FUNC_W-1:0] FUNC_SB   = 5'd17;
	localparam logic [FUNC_W-1:0] FUNC_LUI  = 5'd18;

	typedef enum logic [2:0] {
		CLS_NONE,
		CLS_REG,
		CLS_IMM,
		CLS_LOAD,
		CLS_STORE,
		CLS_LUI
	} cls_t;

	typedef enum logic [3:0] {
		ALU_ADD,
		ALU_SUB,
		ALU_AND,
		ALU_OR,
		ALU_XOR,
		ALU_NOR,
		ALU_SLT,
		ALU_SLL,
		ALU_SRA
	} alu_op_t;

	typedef struct packed {
		cls_t             cls;
		alu_op_t          alu;
		logic             byte_op;
		logic [REG_W-1:0] rd;
		logic [REG_W-1:0] rs_a;
		logic [REG_W-1:0] rs_b;
		logic [XLEN-1:0]  imm;
	} uop_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_FETCH,
		ST_EXEC,
		ST_MOD,
		ST_LOAD,
		ST_STORE,
		ST_WB
	} state_t;

endpackage

`default_nettype wire

// ----- hdl/rsxu_ifs.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface rsxu_instr_if import rsxu_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [FUNC_W-1:0]        func;
	logic [REG_W-1:0]         dest_reg;
	logic [REG_W-1:0]         src_reg_a;
	logic [REG_W-1:0]         src_reg_b;
	logic signed [XLEN-1:0]   immediate;

	modport source (output valid, func, dest_reg, src_reg_a, src_reg_b, immediate,
		input ready);
	modport sink (input valid, func, dest_reg, src_reg_a, src_reg_b, immediate,
		output ready);
endinterface

interface rsxu_result_if import rsxu_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic                   reg_written;
	logic [REG_W-1:0]       written_reg;
	logic signed [XLEN-1:0] written_value;
	logic                   mem_written;
	logic [MADDR_W-1:0]     mem_address;
	logic [XLEN-1:0]        mem_data;

	modport source (output valid, reg_written, written_reg, written_value, mem_written,
		mem_address, mem_data, input ready);
	modport sink (input valid, reg_written, written_reg, written_value, mem_written,
		mem_address, mem_data, output ready);
endinterface

`default_nettype wire

// ----- hdl/riscv_subset_execute_unit_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Executes one decoded instruction per transaction against 32 registers and a
// byte-wide data memory of MEM_BYTES bytes; each instruction gives exactly one result
// transaction. After reset the data memory is zeroed by a sweep over all MEM_BYTES
// addresses during which instr.ready stays low. A two-entry queue parts the decoding
// front from the execute back end, so instructions are accepted while earlier ones
// execute and while a result waits on result.ready. The back end runs one instruction
// at a time through the single byte port of the data memory. Other operations end in
// the execute state; loads and stores move one or four bytes in a load or store
// state, then write back. When MEM_BYTES is not a power of two, each load and store
// first finds its address remainder by multiplying with a reciprocal of MEM_BYTES.
module riscv_subset_execute_unit_core import rsxu_pkg::*; #(
	parameter int MEM_BYTES = 4096
) (
	input  logic          clk,
	input  logic          arst_n,
	rsxu_instr_if.sink    instr,
	rsxu_result_if.source result
);

	logic push, full, q_valid, q_pop, clearing;
	uop_t push_uop, head;

	rsxu_front u_front (
		.instr    (instr),
		.clearing (clearing),
		.full     (full),
		.push     (push),
		.push_uop (push_uop)
	);

	rsxu_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_uop (push_uop),
		.full     (full),
		.pop      (q_pop),
		.q_valid  (q_valid),
		.head     (head)
	);

	rsxu_back #(
		.MEM_BYTES (MEM_BYTES)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_uop    (head),
		.q_pop    (q_pop),
		.clearing (clearing),
		.result   (result)
	);

`ifndef NO_ASSERTIONS
	assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !instr.ready)
		else $error("instruction accepted during memory clear");

	assert property (@(posedge clk) disable iff (!arst_n)
		q_valid && !q_pop |=> q_valid)
		else $error("queue lost an entry");

	assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> !(result.reg_written && result.mem_written))
		else $error("result writes both register and memory");

	assert property (@(posedge clk) disable iff (!arst_n)
		$fell(clearing) |-> !result.valid && !q_pop)
		else $error("work done before memory clear finished");
`endif

endmodule

`default_nettype wire

// ----- hdl/rsxu_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module rsxu_front import rsxu_pkg::*; (
	rsxu_instr_if.sink instr,
	input  logic       clearing,
	input  logic       full,
	output logic       push,
	output uop_t       push_uop
);

	assign instr.ready = !full && !clearing;
	assign push = instr.valid && instr.ready;

	always_comb begin
		push_uop.cls     = CLS_NONE;
		push_uop.alu     = ALU_ADD;
		push_uop.byte_op = 1'b0;
		push_uop.rd      = instr.dest_reg;
		push_uop.rs_a    = instr.src_reg_a;
		push_uop.rs_b    = instr.src_reg_b;
		push_uop.imm     = instr.immediate;
		unique case (instr.func)
			FUNC_ADD: begin push_uop.cls = CLS_REG; push_uop.alu = ALU_ADD; end
			FUNC_SUB: begin push_uop.cls = CLS_REG; push_uop.alu = ALU_SUB; end
			FUNC_AND: begin push_uop.cls = CLS_REG; push_uop.alu = ALU_AND; end
			FUNC_OR: begin push_uop.cls = CLS_REG; push_uop.alu = ALU_OR; end
			FUNC_XOR: begin push_uop.cls = CLS_REG; push_uop.alu = ALU_XOR; end
			FUNC_NOR: begin push_uop.cls = CLS_REG; push_uop.alu = ALU_NOR; end
			FUNC_SLT: begin push_uop.cls = CLS_REG; push_uop.alu = ALU_SLT; end
			FUNC_SLL: begin push_uop.cls = CLS_REG; push_uop.alu = ALU_SLL; end
			FUNC_SRA: begin push_uop.cls = CLS_REG; push_uop.alu = ALU_SRA; end
			FUNC_ADDI: begin push_uop.cls = CLS_IMM; push_uop.alu = ALU_ADD; end
			FUNC_ANDI: begin push_uop.cls = CLS_IMM; push_uop.alu = ALU_AND; end
			FUNC_ORI: begin push_uop.cls = CLS_IMM; push_uop.alu = ALU_OR; end
			FUNC_XORI: begin push_uop.cls = CLS_IMM; push_uop.alu = ALU_XOR; end
			FUNC_SLTI: begin push_uop.cls = CLS_IMM; push_uop.alu = ALU_SLT; end
			FUNC_LW: begin push_uop.cls = CLS_LOAD; end
			FUNC_LB: begin push_uop.cls = CLS_LOAD; push_uop.byte_op = 1'b1; end
			FUNC_SW: begin
				push_uop.cls  = CLS_STORE;
				push_uop.rs_b = instr.dest_reg;
			end
			FUNC_SB: begin
				push_uop.cls     = CLS_STORE;
				push_uop.byte_op = 1'b1;
				push_uop.rs_b    = instr.dest_reg;
			end
			FUNC_LUI: begin push_uop.cls = CLS_LUI; end
			default: begin push_uop.cls = CLS_NONE; end
		endcase
	end

endmodule

`default_nettype wire

// ----- hdl/rsxu_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

module rsxu_queue import rsxu_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  uop_t push_uop,
	output logic full,
	input  logic pop,
	output logic q_valid,
	output uop_t head
);

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PW-1:0] PTR_LAST = PW'(QUEUE_DEPTH - 1);

	uop_t          entries_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full    = count_q == CW'(QUEUE_DEPTH);
	assign q_valid = count_q != '0;
	assign head    = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_uop;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ----- hdl/rsxu_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module rsxu_back import rsxu_pkg::*; #(
	parameter int MEM_BYTES = 4096
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_valid,
	input  uop_t            q_uop,
	output logic            q_pop,
	output logic            clearing,
	rsxu_result_if.source   result
);

	localparam int AW = $clog2(MEM_BYTES);
	localparam bit POW2 = (MEM_BYTES & (MEM_BYTES - 1)) == 0;
	localparam logic [AW:0]   MEM_SIZE = (AW + 1)'(MEM_BYTES);
	localparam logic [AW-1:0] MEM_LAST = AW'(MEM_BYTES - 1);
	localparam logic [XLEN-1:0] MEM_W  = XLEN'(MEM_BYTES);
	localparam logic [2*XLEN-1:0] RECIP_W = ((2*XLEN)'(1) << XLEN) / (2*XLEN)'(MEM_BYTES);
	localparam logic [XLEN-1:0] RECIP  = RECIP_W[XLEN-1:0];

	typedef struct packed {
		logic               reg_written;
		logic [REG_W-1:0]   written_reg;
		logic [XLEN-1:0]    written_value;
		logic               mem_written;
		logic [MADDR_W-1:0] mem_address;
		logic [XLEN-1:0]    mem_data;
	} result_t;

	state_t          state_q, state_d;
	uop_t            uop_q;
	logic [XLEN-1:0] regs_q [NUM_REGS];
	logic [NUM_REGS-1:0] rvalid_q;
	logic [XLEN-1:0] opnd_a_q, opnd_b_q;
	logic            va_q, vb_q;
	logic [7:0]      mem_q [MEM_BYTES];
	logic [7:0]      rdata_q;
	logic [AW-1:0]   clr_q, base_q;
	logic [AW:0]     rem_q;
	logic [XLEN-1:0] sum_q, word_q;
	logic [2*XLEN-1:0] prod_q;
	logic [1:0]      cnt_q;
	logic [2:0]      k_q;
	logic            out_valid_q;
	result_t         res_q;

	logic [XLEN-1:0] a, b, b_op, alu_res, exec_val, sum, load_val, store_val, base32;
	logic [AW:0]     rem_fix, ba_ext, ba_wrap;
	logic [AW-1:0]   ba, mem_wa;
	logic [7:0]      mem_wd;
	logic [2:0]      n_bytes;
	logic [1:0]      lane;
	logic            rd_nz, out_free, mem_we, mem_re, reg_we, out_push, mod_last;
	logic [XLEN-1:0] reg_wd;
	result_t         out_d;

	assign a        = va_q ? opnd_a_q : '0;
	assign b        = vb_q ? opnd_b_q : '0;
	assign b_op     = (uop_q.cls == CLS_IMM) ? uop_q.imm : b;
	assign sum      = a + uop_q.imm;
	assign exec_val = (uop_q.cls == CLS_LUI) ? (uop_q.imm << 12) : alu_res;
	assign rd_nz    = uop_q.rd != '0;
	assign out_free = !out_valid_q || result.ready;
	assign clearing = state_q == ST_CLEAR;
	assign n_bytes  = uop_q.byte_op ? 3'd1 : 3'd4;
	assign lane     = 2'(k_q - 3'd1);
	assign mod_last = cnt_q == 2'd2;
	assign base32   = XLEN'(base_q);

	// address remainder for non power-of-two sizes, quotient estimate is off by at most one
	assign rem_fix = (rem_q >= MEM_SIZE) ? rem_q - MEM_SIZE : rem_q;

	// byte address of the current lane, wrapped
	assign ba_ext  = {1'b0, base_q} + (AW + 1)'(k_q[1:0]);
	assign ba_wrap = ba_ext - MEM_SIZE;
	assign ba      = (ba_ext >= MEM_SIZE) ? ba_wrap[AW-1:0] : ba_ext[AW-1:0];

	assign load_val  = uop_q.byte_op ? {{24{word_q[7]}}, word_q[7:0]} : word_q;
	assign store_val = uop_q.byte_op ? {24'd0, b[7:0]} : b;

	always_comb begin
		unique case (uop_q.alu)
			ALU_ADD: alu_res = a + b_op;
			ALU_SUB: alu_res = a - b_op;
			ALU_AND: alu_res = a & b_op;
			ALU_OR:  alu_res = a | b_op;
			ALU_XOR: alu_res = a ^ b_op;
			ALU_NOR: alu_res = ~(a | b_op);
			ALU_SLT: alu_res = XLEN'($signed(a) < $signed(b_op));
			ALU_SLL: alu_res = a << b_op[4:0];
			ALU_SRA: alu_res = $unsigned($signed(a) >>> b_op[4:0]);
			default: alu_res = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		q_pop    = 1'b0;
		reg_we   = 1'b0;
		reg_wd   = exec_val;
		mem_we   = 1'b0;
		mem_re   = 1'b0;
		mem_wa   = ba;
		mem_wd   = '0;
		out_push = 1'b0;
		out_d    = '0;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
				mem_wa = clr_q;
				if (clr_q == MEM_LAST) begin
					state_d = ST_FETCH;
				end
			end
			ST_FETCH: begin
				if (q_valid) begin
					q_pop   = 1'b1;
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (uop_q.cls == CLS_LOAD || uop_q.cls == CLS_STORE) begin
					if (!POW2) begin
						state_d = ST_MOD;
					end else if (uop_q.cls == CLS_LOAD) begin
						state_d = ST_LOAD;
					end else begin
						state_d = ST_STORE;
					end
				end else if (out_free) begin
					out_push = 1'b1;
					if (uop_q.cls != CLS_NONE && rd_nz) begin
						reg_we              = 1'b1;
						out_d.reg_written   = 1'b1;
						out_d.written_reg   = uop_q.rd;
						out_d.written_value = exec_val;
					end
					state_d = ST_FETCH;
				end
			end
			ST_MOD: begin
				if (mod_last) begin
					state_d = (uop_q.cls == CLS_LOAD) ? ST_LOAD : ST_STORE;
				end
			end
			ST_LOAD: begin
				mem_re = k_q < n_bytes;
				if (k_q == n_bytes) begin
					state_d = ST_WB;
				end
			end
			ST_STORE: begin
				mem_we = 1'b1;
				mem_wd = b[{k_q[1:0], 3'b000} +: 8];
				if (k_q == n_bytes - 3'd1) begin
					state_d = ST_WB;
				end
			end
			ST_WB: begin
				reg_wd = load_val;
				if (out_free) begin
					out_push          = 1'b1;
					out_d.mem_address = base32[MADDR_W-1:0];
					if (uop_q.cls == CLS_LOAD) begin
						if (rd_nz) begin
							reg_we              = 1'b1;
							out_d.reg_written   = 1'b1;
							out_d.written_reg   = uop_q.rd;
							out_d.written_value = load_val;
						end
					end else begin
						out_d.mem_written = 1'b1;
						out_d.mem_data    = store_val;
					end
					state_d = ST_FETCH;
				end
			end
			default: begin
				state_d = ST_FETCH;
			end
		endcase
	end

	// register file
	always_ff @(posedge clk) begin
		if (reg_we) begin
			regs_q[uop_q.rd] <= reg_wd;
		end
		if (q_pop) begin
			opnd_a_q <= regs_q[q_uop.rs_a];
			opnd_b_q <= regs_q[q_uop.rs_b];
		end
	end

	// data memory
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rdata_q <= mem_q[ba];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rvalid_q    <= '0;
			va_q        <= 1'b0;
			vb_q        <= 1'b0;
			clr_q       <= '0;
			cnt_q       <= '0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (reg_we) begin
				rvalid_q[uop_q.rd] <= 1'b1;
			end
			if (q_pop) begin
				va_q <= rvalid_q[q_uop.rs_a];
				vb_q <= rvalid_q[q_uop.rs_b];
			end
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (state_q == ST_EXEC) begin
				cnt_q <= '0;
				k_q   <= '0;
			end
			if (state_q == ST_MOD) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (state_q == ST_LOAD || state_q == ST_STORE) begin
				k_q <= k_q + 1'b1;
			end
			if (out_push) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			uop_q <= q_uop;
		end
		if (state_q == ST_EXEC) begin
			sum_q  <= sum;
			base_q <= sum[AW-1:0];
		end
		if (state_q == ST_MOD) begin
			if (cnt_q == 2'd0) begin
				prod_q <= sum_q * RECIP;
			end
			if (cnt_q == 2'd1) begin
				rem_q <= (AW + 1)'(sum_q - prod_q[2*XLEN-1:XLEN] * MEM_W);
			end
			if (mod_last) begin
				base_q <= rem_fix[AW-1:0];
			end
		end
		if (state_q == ST_LOAD && k_q != 3'd0) begin
			word_q[{lane, 3'b000} +: 8] <= rdata_q;
		end
		if (out_push) begin
			res_q <= out_d;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.reg_written   = res_q.reg_written;
	assign result.written_reg   = res_q.written_reg;
	assign result.written_value = res_q.written_value;
	assign result.mem_written   = res_q.mem_written;
	assign result.mem_address   = res_q.mem_address;
	assign result.mem_data      = res_q.mem_data;

endmodule

`default_nettype wire
